// File: sv/socket_demux_wildcard_match_core_macros.svh
// Assertion macros used by the checker file sdwm_chk.sv.
`ifndef SOCKET_DEMUX_WILDCARD_MATCH_CORE_MACROS_SVH
`define SOCKET_DEMUX_WILDCARD_MATCH_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SDWM_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SDWM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/sdwm_pkg.sv
`default_nettype none
package sdwm_pkg;

	localparam int SLOTS_DEF = 64;
	localparam int SLOT_W = 6;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// Field compare result codes.
	localparam logic [1:0] COST_EXACT = 2'd0;
	localparam logic [1:0] COST_WILD = 2'd1;
	localparam logic [1:0] COST_REJECT = 2'd2;

	localparam logic [2:0] NO_MATCH_COUNT = 3'd4;

	typedef struct packed {
		logic [7:0]  kind;
		logic [7:0]  protocol;
		logic [31:0] local_addr;
		logic [15:0] local_port;
		logic [31:0] remote_addr;
		logic [15:0] remote_port;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic start;
		logic hit_en;
		logic entry_valid;
	} cmp_ctrl_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
		logic [1:0]        count;
	} best_t;

	function automatic logic [1:0] field_cost(input logic [31:0] stored, input logic [31:0] seen);
		logic [1:0] c;
		if (stored == seen) begin
			c = COST_EXACT;
		end else if (stored == 32'd0) begin
			c = COST_WILD;
		end else begin
			c = COST_REJECT;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// File: sv/sdwm_ifs.sv
`default_nettype none
interface sdwm_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [5:0]  slot;
	logic [7:0]  kind;
	logic [7:0]  protocol;
	logic [31:0] local_addr;
	logic [15:0] local_port;
	logic [31:0] remote_addr;
	logic [15:0] remote_port;

	modport src (output valid, op, slot, kind, protocol, local_addr, local_port,
		remote_addr, remote_port, input ready);
	modport snk (input valid, op, slot, kind, protocol, local_addr, local_port,
		remote_addr, remote_port, output ready);
endinterface

interface sdwm_rsp_if;
	logic       valid;
	logic       ready;
	logic       found;
	logic [5:0] match_slot;
	logic [1:0] wildcard_count;

	modport src (output valid, found, match_slot, wildcard_count, input ready);
	modport snk (input valid, found, match_slot, wildcard_count, output ready);
endinterface
`default_nettype wire

// File: sv/socket_demux_wildcard_match_core.sv
// Channel | Interface   | Carries
// req     | sdwm_req_if | op, slot, kind, protocol, local/remote address and port
// rsp     | sdwm_rsp_if | found, match_slot, wildcard_count
//
// A write or clear finishes on its transfer, and its result is loaded into the output register on that transfer.
// A lookup reads the entry memory one slot per cycle through its single read port;
// the result passes the scan, drain and done states, and no new request is taken
// until the lookup has returned to idle.
// Reset empties the table through the valid flip-flops; no clearing pass is needed.
// A stalled result holds the next request only once the output register is full.
`default_nettype none
module socket_demux_wildcard_match_core #(
	parameter int SLOTS = sdwm_pkg::SLOTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	sdwm_req_if.snk  req,
	sdwm_rsp_if.src  rsp
);
	import sdwm_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	state_t           state_q;
	state_t           state_d;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] idx_s1;
	logic             rd_s1;
	logic             valid_s1;
	logic [SLOTS-1:0] valid_q;
	entry_t           key_q;
	entry_t           req_entry;
	entry_t           rd_entry;
	logic [IDX_W+5:0] slot_wide;
	logic [IDX_W-1:0] wr_idx;
	logic             slot_ok;
	logic             accept;
	logic             out_free;
	logic             scan_en;
	logic             done_load;
	logic             ram_we;
	cmp_ctrl_t        cmp_ctrl;
	best_t            best;
	logic             out_valid_q;
	logic             out_found_q;
	logic [5:0]       out_slot_q;
	logic [1:0]       out_count_q;

	always_comb begin
		req_entry.kind = req.kind;
		req_entry.protocol = req.protocol;
		req_entry.local_addr = req.local_addr;
		req_entry.local_port = req.local_port;
		req_entry.remote_addr = req.remote_addr;
		req_entry.remote_port = req.remote_port;
		slot_wide = (IDX_W + 6)'(req.slot);
		wr_idx = slot_wide[IDX_W-1:0];
		slot_ok = (32'(req.slot) < SLOTS);
		out_free = !out_valid_q || rsp.ready;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (req.op == OP_LOOKUP)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (idx_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == ST_IDLE) && out_free;
		accept = req.valid && req.ready;
		scan_en = (state_q == ST_SCAN);
		done_load = (state_q == ST_DONE) && out_free;
		ram_we = accept && (req.op == OP_WRITE) && slot_ok;
		cmp_ctrl.start = accept && (req.op == OP_LOOKUP);
		cmp_ctrl.hit_en = rd_s1;
		cmp_ctrl.entry_valid = valid_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			rd_s1 <= 1'b0;
			valid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1 <= scan_en;
			if (cmp_ctrl.start) begin
				idx_q <= '0;
			end else if (scan_en) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (accept && slot_ok && (req.op == OP_WRITE)) begin
				valid_q[wr_idx] <= 1'b1;
			end else if (accept && slot_ok && (req.op == OP_CLEAR)) begin
				valid_q[wr_idx] <= 1'b0;
			end
			if ((accept && (req.op != OP_LOOKUP)) || done_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		valid_s1 <= valid_q[idx_q];
		if (cmp_ctrl.start) begin
			key_q <= req_entry;
		end
		if (accept && (req.op != OP_LOOKUP)) begin
			out_found_q <= 1'b0;
			out_slot_q <= '0;
			out_count_q <= '0;
		end else if (done_load) begin
			out_found_q <= best.found;
			out_slot_q <= best.slot;
			out_count_q <= best.count;
		end
	end

	sdwm_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_idx),
		.wdata(req_entry),
		.re   (scan_en),
		.raddr(idx_q),
		.rdata(rd_entry)
	);

	sdwm_cmp #(
		.IDX_W(IDX_W)
	) u_cmp (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (cmp_ctrl),
		.entry (rd_entry),
		.key   (key_q),
		.idx   (idx_s1),
		.best  (best)
	);

	assign rsp.valid = out_valid_q;
	assign rsp.found = out_found_q;
	assign rsp.match_slot = out_slot_q;
	assign rsp.wildcard_count = out_count_q;

endmodule
`default_nettype wire

// File: sv/sdwm_ram.sv
`default_nettype none
module sdwm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: sv/sdwm_cmp.sv
`default_nettype none
module sdwm_cmp #(
	parameter int IDX_W = 6
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sdwm_pkg::cmp_ctrl_t ctrl,
	input  wire sdwm_pkg::entry_t   entry,
	input  wire sdwm_pkg::entry_t   key,
	input  wire logic [IDX_W-1:0]   idx,
	output sdwm_pkg::best_t         best
);
	import sdwm_pkg::*;

	logic [1:0]        cost_la;
	logic [1:0]        cost_ra;
	logic [1:0]        cost_rp;
	logic              exact_ok;
	logic              hit;
	logic [1:0]        cnt;
	logic [IDX_W+5:0]  idx_wide;
	logic [2:0]        best_count_q;
	logic [SLOT_W-1:0] best_slot_q;

	always_comb begin
		cost_la = field_cost(entry.local_addr, key.local_addr);
		cost_ra = field_cost(entry.remote_addr, key.remote_addr);
		cost_rp = field_cost(32'(entry.remote_port), 32'(key.remote_port));
		exact_ok = (entry.kind == key.kind) && (entry.local_port == key.local_port) &&
			((entry.protocol == key.protocol) || (entry.protocol == 8'd0));
		cnt = 2'(cost_la[0]) + 2'(cost_ra[0]) + 2'(cost_rp[0]);
		hit = ctrl.hit_en && ctrl.entry_valid && exact_ok &&
			!(cost_la[1] || cost_ra[1] || cost_rp[1]);
		idx_wide = (IDX_W + 6)'(idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_count_q <= NO_MATCH_COUNT;
			best_slot_q <= '0;
		end else if (ctrl.start) begin
			best_count_q <= NO_MATCH_COUNT;
			best_slot_q <= '0;
		end else if (hit && ({1'b0, cnt} < best_count_q)) begin
			best_count_q <= {1'b0, cnt};
			best_slot_q <= idx_wide[SLOT_W-1:0];
		end
	end

	always_comb begin
		best.found = (best_count_q != NO_MATCH_COUNT);
		best.slot = best.found ? best_slot_q : '0;
		best.count = best.found ? best_count_q[1:0] : 2'd0;
	end

endmodule
`default_nettype wire

// File: sv/sdwm_chk.sv
`default_nettype none
`include "socket_demux_wildcard_match_core_macros.svh"
module sdwm_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_valid,
	input wire logic       req_ready,
	input wire logic [1:0] req_op,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic       rsp_found,
	input wire logic [5:0] rsp_match_slot,
	input wire logic [1:0] rsp_wildcard_count
);
	import sdwm_pkg::*;

	`SDWM_ASSERT_SAME(a_miss_zero, clk, arst_n, rsp_valid && !rsp_found,
		(rsp_match_slot == 6'd0) && (rsp_wildcard_count == 2'd0),
		"A miss must carry slot and count of zero.")
	`SDWM_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready,
		rsp_valid && $stable(rsp_found) && $stable(rsp_match_slot) &&
		$stable(rsp_wildcard_count),
		"A stalled response changed.")
	`SDWM_ASSERT_NEXT(a_lookup_busy, clk, arst_n,
		req_valid && req_ready && (req_op == OP_LOOKUP), !req_ready,
		"A request was taken during a lookup scan.")
	`SDWM_ASSERT_NEXT(a_update_result, clk, arst_n,
		req_valid && req_ready && (req_op != OP_LOOKUP), rsp_valid && !rsp_found,
		"A write or clear gave no empty result.")

endmodule

bind socket_demux_wildcard_match_core sdwm_chk u_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.req_op            (req.op),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_found         (rsp.found),
	.rsp_match_slot    (rsp.match_slot),
	.rsp_wildcard_count(rsp.wildcard_count)
);
`default_nettype wire
